[rtl/svr_pkg.sv]
// svr_pkg: shared types, constants and note tables for the sine voice
// with release; no dependencies, imported by sine_voice_with_release
package svr_pkg;

   // parameter defaults
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int PHASE_BITS_DEF       = 32;

   // field and register widths
   localparam int KIND_W  = 2;
   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int RATE_W  = 18;
   localparam int Q15_W   = 16;
   localparam int OCT_W   = 4;
   localparam int SEMI_W  = 4;
   localparam int FREQ_W  = 29;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

   // fixed-point constants, Q1.15, and the reset sample rate
   localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;
   localparam logic [Q15_W-1:0]  GAIN_ONE    = 16'd32768;
   localparam logic [Q15_W-1:0]  GAIN_DECAY  = 16'd32440;
   localparam logic [Q15_W-1:0]  GAIN_FLOOR  = 16'd163;
   localparam logic [Q15_W-1:0]  LEVEL_SCALE = 16'd4915;
   localparam logic [Q15_W-1:0]  LEVEL_MAX   = 16'd4915;
   localparam logic [Q15_W-1:0]  SIN_A       = 16'd51472;
   localparam logic [Q15_W-1:0]  SIN_B       = 16'd21024;
   localparam logic [Q15_W-1:0]  SIN_C       = 16'd2320;
   localparam logic [Q15_W-1:0]  POS_MAX     = 16'd32767;
   localparam logic [Q15_W-1:0]  NEG_MAX     = 16'd32768;

   // level = velocity * 4915 / 127 as velocity * (4915 * ceil(2^27 / 127)) >> 27,
   // exact for every 7-bit velocity
   localparam int                     LEVEL_SHIFT   = 27;
   localparam int                     LEVEL_RECIP_W = 33;
   localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP  =
      LEVEL_RECIP_W'(LEVEL_SCALE) * LEVEL_RECIP_W'(1056833);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Z2,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_LVL,
      ST_GAIN,
      ST_DECAY,
      ST_OUT,
      ST_LVMUL,
      ST_STDIV
   } state_type;

   // octave of a midi note: count of octave boundaries passed
   function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] note);
      logic [OCT_W-1:0] oct;
      oct = '0;
      for (int k = 1; k <= 10; k++) begin
         if (note >= NOTE_W'(12 * k)) oct = oct + OCT_W'(1);
      end
      return oct;
   endfunction

   // semitone within the octave
   function automatic logic [SEMI_W-1:0] note_semitone(input logic [NOTE_W-1:0] note);
      logic [OCT_W-1:0]  oct;
      logic [NOTE_W-1:0] base;
      oct  = note_octave(note);
      base = NOTE_W'(oct) * NOTE_W'(12);
      return SEMI_W'(note - base);
   endfunction

   // octave 4 frequencies in hz * 2^20, rounded
   function automatic logic [FREQ_W-1:0] octave4_freq(input logic [SEMI_W-1:0] semi);
      logic [FREQ_W-1:0] f;
      unique case (semi)
         4'd0:    f = 29'd274334289;
         4'd1:    f = 29'd290647054;
         4'd2:    f = 29'd307929828;
         4'd3:    f = 29'd326240288;
         4'd4:    f = 29'd345639545;
         4'd5:    f = 29'd366192342;
         4'd6:    f = 29'd387967272;
         4'd7:    f = 29'd411037006;
         4'd8:    f = 29'd435478539;
         4'd9:    f = 29'd461373440;
         4'd10:   f = 29'd488808132;
         4'd11:   f = 29'd517874177;
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

[rtl/sine_voice_with_release.sv]
// sine_voice_with_release: one sine voice with level and exponential release,
// built on one shared 16x16 multiplier, a one-bit-per-cycle divider and a
// constant multiply for the level; depends on svr_pkg
//
// usage
//   req channel (valid/ready): kind, note, velocity, allow_tail_off. a word
//   is taken only while the sequencer is idle; req_ready is low while a word
//   is at work or a result waits for the output register.
//   rsp channel (valid/ready): sample, active; one word per tick, none for
//   note start, note stop or the unused kind.
//   csr port: csr_we writes csr_wdata into the sample rate at once.
// sequence
//   tick on a sounding voice: the seven passes through the shared multiplier
//   (four for the sine polynomial, level, release gain, gain decay) in
//   ST_Z2 to ST_DECAY, then the hand-off to the output register in ST_OUT.
//   tick on a silent voice: straight from idle to the hand-off in ST_OUT.
//   note start: ST_LVMUL, then one restoring division of PHASE_BITS+15
//   bits for the phase step in ST_STDIV.
//   note stop: done in the idle state alone.
// reset clears phase, step, level and gain, sets the rate to 48000 and
// empties the output register. a stalled receiver holds the result; the
// block then waits with its next result and takes no word.
module sine_voice_with_release #(
   parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int PHASE_BITS       = svr_pkg::PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [svr_pkg::KIND_W-1:0] req_kind,
   input  logic [svr_pkg::NOTE_W-1:0] req_note,
   input  logic [svr_pkg::VEL_W-1:0]  req_velocity,
   input  logic                       req_allow_tail_off,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [15:0]         rsp_sample,
   output logic                       rsp_active,
   input  logic                       csr_we,
   input  logic [svr_pkg::RATE_W-1:0] csr_wdata
);
   import svr_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int DW    = PHASE_BITS + 15;
   localparam int CW    = $clog2(DW);
   localparam int DSR_W = RATE_W + 1;
   localparam int REM_W = DSR_W + 1;
   localparam int SH_W  = OCT_W + 1;
   localparam int LP_W  = VEL_W + LEVEL_RECIP_W;

   // state
   state_type               state_ff, state_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [PHASE_BITS-1:0]   step_ff, step_in;
   logic [Q15_W-1:0]        level_ff, level_in;
   logic [Q15_W-1:0]        gain_ff, gain_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // datapath payload
   logic [NOTE_W-1:0]       note_ff, note_in;
   logic [VEL_W-1:0]        vel_ff, vel_in;
   logic [Q15_W-1:0]        z_ff, z_in;
   logic [Q15_W-1:0]        z2_ff, z2_in;
   logic [Q15_W-1:0]        k_ff, k_in;
   logic [Q15_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [DW-1:0]           div_ff, div_in;
   logic [DSR_W-1:0]        rem_ff, rem_in;
   logic [DSR_W-1:0]        dsr_ff, dsr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [Q15_W-1:0]        res_sample_ff, res_sample_in;
   logic                    res_active_ff, res_active_in;
   logic [Q15_W-1:0]        rsp_sample_ff, rsp_sample_in;
   logic                    rsp_active_ff, rsp_active_in;

   // shared multiplier
   logic [Q15_W-1:0]        mul_a, mul_b;
   logic [2*Q15_W-1:0]      mul_p;
   logic [Q15_W:0]          mul_hi;

   assign mul_p  = mul_a * mul_b;
   assign mul_hi = mul_p[2*Q15_W-1:15];

   // level from velocity by constant reciprocal multiply
   logic [LP_W-1:0]         lvl_prod;

   assign lvl_prod = LP_W'(vel_ff) * LP_W'(LEVEL_RECIP);

   // divider step, restoring, one quotient bit per cycle
   logic [REM_W-1:0]        rem_sh;
   logic                    div_ge;
   logic [DSR_W-1:0]        rem_next;
   logic [DW-1:0]           div_next;
   logic                    div_done;

   assign rem_sh   = {rem_ff, div_ff[DW-1]};
   assign div_ge   = rem_sh >= REM_W'(dsr_ff);
   assign rem_next = div_ge ? DSR_W'(rem_sh - REM_W'(dsr_ff)) : DSR_W'(rem_sh);
   assign div_next = {div_ff[DW-2:0], div_ge};
   assign div_done = cnt_ff == CW'(DW - 1);

   // sine table index and quarter position from the phase
   logic [IDX_W-1:0]        sin_idx;
   logic [15:0]             turn;
   logic [Q15_W-1:0]        z_raw;

   assign sin_idx = phase_ff[PHASE_BITS-1 -: IDX_W];
   assign turn    = 16'({sin_idx, {(16 - IDX_W){1'b0}}});
   assign z_raw   = {1'b0, turn[13:0], 1'b0};

   // phase step dividend and divisor
   logic [RATE_W-1:0]       rate_eff;
   logic [DW-1:0]           freq_num;

   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign freq_num = DW'(octave4_freq(note_semitone(note_ff)))
                     << (SH_W'(note_octave(note_ff)) + SH_W'(PHASE_BITS - 24));

   // output saturation and release decay of the current word
   logic [Q15_W-1:0]        sat_sample;
   logic [Q15_W-1:0]        gain_dec;

   assign sat_sample = neg_ff ? Q15_W'(17'd0 - 17'((mag_ff > NEG_MAX) ? NEG_MAX : mag_ff))
                              : ((mag_ff > POS_MAX) ? POS_MAX : mag_ff);
   assign gain_dec   = mul_hi[Q15_W-1:0];

   assign req_ready  = state_ff == ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         phase_ff     <= '0;
         step_ff      <= '0;
         level_ff     <= '0;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      note_ff       <= note_in;
      vel_ff        <= vel_in;
      z_ff          <= z_in;
      z2_ff         <= z2_in;
      k_ff          <= k_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      cnt_ff        <= cnt_in;
      res_sample_ff <= res_sample_in;
      res_active_ff <= res_active_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
   end

   // sequencer: next state, multiplier operands, datapath updates
   always_comb begin
      state_in      = state_ff;
      rate_in       = csr_we ? csr_wdata : rate_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      level_in      = level_ff;
      gain_in       = gain_ff;
      note_in       = note_ff;
      vel_in        = vel_ff;
      z_in          = z_ff;
      z2_in         = z2_ff;
      k_in          = k_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      res_sample_in = res_sample_ff;
      res_active_in = res_active_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      mul_a         = z_ff;
      mul_b         = z_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               note_in = req_note;
               vel_in  = req_velocity;
               priority case (req_kind)
                  KIND_TICK: begin
                     if (step_ff == '0) begin
                        res_sample_in = '0;
                        res_active_in = 1'b0;
                        state_in      = ST_OUT;
                     end else begin
                        z_in     = turn[14] ? (NEG_MAX - z_raw) : z_raw;
                        neg_in   = turn[15];
                        state_in = ST_Z2;
                     end
                  end
                  KIND_START: begin
                     phase_in = '0;
                     gain_in  = '0;
                     state_in = ST_LVMUL;
                  end
                  KIND_STOP: begin
                     if (req_allow_tail_off) begin
                        if (gain_ff == '0) gain_in = GAIN_ONE;
                     end else begin
                        step_in = '0;
                        gain_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // z^2
         ST_Z2: begin
            mul_a    = z_ff;
            mul_b    = z_ff;
            z2_in    = mul_hi[Q15_W-1:0];
            state_in = ST_K1;
         end

         // b - c*z^2
         ST_K1: begin
            mul_a    = SIN_C;
            mul_b    = z2_ff;
            k_in     = SIN_B - mul_hi[Q15_W-1:0];
            state_in = ST_K2;
         end

         // a - z^2*(b - c*z^2)
         ST_K2: begin
            mul_a    = z2_ff;
            mul_b    = k_ff;
            k_in     = SIN_A - mul_hi[Q15_W-1:0];
            state_in = ST_K3;
         end

         // sine magnitude, clamped
         ST_K3: begin
            mul_a    = z_ff;
            mul_b    = k_ff;
            mag_in   = (mul_hi > (Q15_W+1)'(POS_MAX)) ? POS_MAX : mul_hi[Q15_W-1:0];
            state_in = ST_LVL;
         end

         // scale by level
         ST_LVL: begin
            mul_a    = mag_ff;
            mul_b    = level_ff;
            mag_in   = mul_hi[Q15_W-1:0];
            state_in = ST_GAIN;
         end

         // scale by release gain while release runs
         ST_GAIN: begin
            mul_a = mag_ff;
            mul_b = gain_ff;
            if (gain_ff != '0) mag_in = mul_hi[Q15_W-1:0];
            state_in = ST_DECAY;
         end

         // saturate, advance phase, decay gain and end the voice at the gain floor
         ST_DECAY: begin
            mul_a         = gain_ff;
            mul_b         = GAIN_DECAY;
            res_sample_in = sat_sample;
            phase_in      = phase_ff + step_ff;
            res_active_in = 1'b1;
            if (gain_ff != '0) begin
               gain_in = gain_dec;
               if (gain_dec <= GAIN_FLOOR) begin
                  step_in       = '0;
                  gain_in       = '0;
                  res_active_in = 1'b0;
               end
            end
            state_in = ST_OUT;
         end

         // hand the word to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_sample_in = res_sample_ff;
               rsp_active_in = res_active_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         // velocity * 4915 / 127, then set up the phase step division
         ST_LVMUL: begin
            level_in = Q15_W'(lvl_prod[LP_W-1:LEVEL_SHIFT]);
            div_in   = freq_num;
            rem_in   = '0;
            dsr_in   = {rate_eff, 1'b0};
            cnt_in   = '0;
            state_in = ST_STDIV;
         end

         // phase step = frequency * 2^PHASE_BITS / rate
         ST_STDIV: begin
            div_in = div_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CW'(1);
            if (div_done) begin
               step_in  = div_next[PHASE_BITS-1:0];
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // release gain never exceeds unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("release gain above unity");

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STDIV) |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   // the level from the reciprocal multiply is in range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STDIV) |-> (level_ff <= LEVEL_MAX))
      else $error("level above full velocity scale");

   // clamped sine magnitude enters the level pass
   a_sine_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LVL) |-> (mag_ff <= POS_MAX))
      else $error("sine magnitude not clamped");

endmodule
